// File: sv/ppsb_pkg.sv
// ----------------------------------------------------------------------------
// ppsb_pkg
// Shared constants, types and helpers of the ping-pong sample buffer.
// ----------------------------------------------------------------------------
package ppsb_pkg;

  // Size of one half of the buffer, in bytes.
  localparam int HALF_BYTES = 512;
  localparam int NUM_HALVES = 2;
  localparam int STORE_DEPTH = NUM_HALVES * HALF_BYTES;
  localparam int HALF_AW = $clog2(HALF_BYTES);
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int BYTE_W = 8;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W = 32;
  localparam int SB_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [SB_W-1:0] SAMPLE_BYTES_RST = 3'd2;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_CAP,
    S_DONE
  } state_t;

  // Store address of a byte position within a half.
  function automatic logic [STORE_AW-1:0] store_addr(input logic half,
                                                     input logic [HALF_AW-1:0] pos);
    logic [STORE_AW-1:0] base;
    base = half ? STORE_AW'(HALF_BYTES) : '0;
    return base + STORE_AW'(pos);
  endfunction

  // Advance a position within a half by up to four bytes, wrapping once.
  function automatic logic [HALF_AW-1:0] pos_add(input logic [HALF_AW-1:0] pos,
                                                 input logic [2:0] step);
    logic [HALF_AW:0] sum;
    sum = {1'b0, pos} + (HALF_AW+1)'(step);
    if (sum >= (HALF_AW+1)'(HALF_BYTES)) begin
      sum = sum - (HALF_AW+1)'(HALF_BYTES);
    end
    return sum[HALF_AW-1:0];
  endfunction

endpackage

// File: sv/ppsb_ram.sv
// ----------------------------------------------------------------------------
// ppsb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ping_pong_sample_buffer_top.sv
// ----------------------------------------------------------------------------
// ping_pong_sample_buffer_top
// Two-half audio byte buffer: a writer fills one half while a reader gathers
// little-endian samples from the other.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall with a kind (restart, write one
// byte, read one sample) and a byte. Every request gives exactly one result on
// out_valid/out_stall carrying the sample and the status flags.
// Configuration (sample_bytes, data_size) is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
// Flow: a restart, a write or a refused read goes from accept straight to the
// result state. A read that delivers a sample walks the byte-wide store one
// byte at a time, issuing each address and then capturing the registered read
// data. The block takes one request at a time; in_stall is high from accept
// until the result is loaded into the output register.
// The output register holds a result while out_stall is high, and the next
// request may be accepted meanwhile; its result waits until the output frees.
// Reset clears the counters, the halves and the configuration registers
// (sample_bytes to 2, data_size to 0). The store contents are not cleared.
// ----------------------------------------------------------------------------
module ping_pong_sample_buffer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [ppsb_pkg::BYTE_W-1:0]       byte_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ppsb_pkg::SAMPLE_W-1:0]     sample,
  output logic                              sample_valid,
  output logic                              byte_taken,
  output logic                              write_ready,
  output logic                              finished,
  output logic                              underrun,
  input  logic                              cfg_we,
  input  logic [ppsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppsb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ppsb_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  logic [SB_W-1:0]    sample_bytes;
  logic [COUNT_W-1:0] data_size;

  // Buffer control state.
  logic [COUNT_W-1:0] read_count;
  logic [COUNT_W-1:0] write_count;
  logic [HALF_AW-1:0] read_pos;
  logic [HALF_AW-1:0] write_pos;
  logic               read_half;
  logic               write_allowed;
  logic               primed;

  // Read walk and pending result.
  logic [HALF_AW-1:0]  rd_off;
  logic [1:0]          rd_idx;
  logic [1:0]          nb_last;
  logic [SAMPLE_W-1:0] res_sample;
  logic                res_valid;
  logic                res_taken;
  logic                res_under;

  // Store interface.
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [STORE_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic accept;
  logic done_now;
  logic write_ok;
  logic read_go;
  logic out_free;
  logic [2:0] nb;
  logic [COUNT_W:0] rc_sum;
  logic [COUNT_W-1:0] rc_new;
  logic [HALF_AW-1:0] rpos_new;

  assign accept   = in_valid && !in_stall;
  assign done_now = read_count >= data_size;
  assign write_ok = write_allowed && (write_count < data_size) && !done_now;
  assign read_go  = !done_now && (read_count < write_count);
  assign out_free = !out_valid || !out_stall;

  // Effective bytes per sample: zero acts as one, above four acts as four.
  always_comb begin
    case (sample_bytes)
      3'd0:    nb = 3'd1;
      3'd1:    nb = 3'd1;
      3'd2:    nb = 3'd2;
      3'd3:    nb = 3'd3;
      3'd4:    nb = 3'd4;
      default: nb = 3'd4;
    endcase
  end

  // Read counter advance with saturation, and the matching half position.
  assign rc_sum   = {1'b0, read_count} + (COUNT_W+1)'(nb);
  assign rc_new   = rc_sum[COUNT_W] ? '1 : rc_sum[COUNT_W-1:0];
  assign rpos_new = pos_add(read_pos, nb);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind_t'(kind) == KIND_READ && read_go) begin
            state_next = S_RD_ISSUE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RD_ISSUE: state_next = S_RD_CAP;
      S_RD_CAP: begin
        if (rd_idx == nb_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD_ISSUE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: input stall and store access. The input is never
  // stalled in idle, so a valid request there is accepted.
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = store_addr(!read_half, write_pos);
    ram_raddr = store_addr(read_half, rd_off);
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_valid && kind_t'(kind) == KIND_WRITE && write_ok;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bytes <= SAMPLE_BYTES_RST;
      data_size    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_BYTES: sample_bytes <= cfg_data[SB_W-1:0];
        CFG_DATA_SIZE:    data_size    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer counters, halves and write permission.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_count    <= '0;
      write_count   <= '0;
      read_pos      <= '0;
      write_pos     <= '0;
      read_half     <= 1'b0;
      write_allowed <= 1'b1;
      primed        <= 1'b0;
    end else if (state == S_IDLE && accept) begin
      case (kind_t'(kind))
        KIND_RESTART: begin
          read_count    <= '0;
          write_count   <= '0;
          read_pos      <= '0;
          write_pos     <= '0;
          read_half     <= 1'b0;
          write_allowed <= 1'b1;
          primed        <= 1'b0;
        end
        KIND_WRITE: begin
          if (write_ok) begin
            write_count <= write_count + 1'b1;
            write_pos   <= pos_add(write_pos, 3'd1);
            // A fill ends at a half boundary or at the end of the data.
            if (write_pos == HALF_AW'(HALF_BYTES - 1) ||
                write_count + 1'b1 == data_size) begin
              if (!primed) begin
                primed    <= 1'b1;
                read_half <= !read_half;
              end else begin
                write_allowed <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (state == S_RD_CAP && rd_idx == nb_last) begin
      // End of a delivered read: advance and swap at a half boundary.
      read_count <= rc_new;
      read_pos   <= rpos_new;
      if (!(rc_new >= data_size) && rpos_new == '0) begin
        read_half     <= !read_half;
        write_allowed <= 1'b1;
      end
    end
  end

  // Pending result and the byte walk of a read.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_sample <= '0;
          res_valid  <= 1'b0;
          res_taken  <= kind_t'(kind) == KIND_WRITE && write_ok;
          res_under  <= kind_t'(kind) == KIND_READ && !done_now && !read_go;
          rd_off     <= read_pos;
          rd_idx     <= '0;
          nb_last    <= 2'(nb - 3'd1);
        end
      end
      S_RD_CAP: begin
        res_sample[rd_idx*BYTE_W +: BYTE_W] <= ram_rdata;
        rd_idx <= rd_idx + 1'b1;
        rd_off <= pos_add(rd_off, 3'd1);
        if (rd_idx == nb_last) begin
          res_valid <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register; status reflects the state after the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      sample       <= res_sample;
      sample_valid <= res_valid;
      byte_taken   <= res_taken;
      underrun     <= res_under;
      write_ready  <= write_ok;
      finished     <= done_now;
    end
  end

  ppsb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(byte_in),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// File: tb/sv/ping_pong_sample_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// ping_pong_sample_buffer_top_tb
// Self-checking testbench of the two-half audio sample buffer.
// ----------------------------------------------------------------------------
// A mirror of the buffer state (store, counters, halves, registers) predicts
// the status and sample of every accepted request. Results are compared field
// by field, in order. Directed tests cover an empty source, refused writes,
// underruns, finished reads, odd sample sizes and the unknown kind. A long
// source crosses both half boundaries, and random sources follow with random
// sizes, random bytes, idle gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module ping_pong_sample_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppsb_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 1950;
  localparam int unsigned TIMEOUT_NS = 10_000_000;

  // One result as the buffer reports it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_valid;
    logic                byte_taken;
    logic                write_ready;
    logic                finished;
    logic                underrun;
  } buffer_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            kind = KIND_NONE;
  logic [BYTE_W-1:0]     byte_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   sample;
  logic                  sample_valid;
  logic                  byte_taken;
  logic                  write_ready;
  logic                  finished;
  logic                  underrun;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the buffer state.
  logic [BYTE_W-1:0]  mirror_bytes [STORE_DEPTH];
  bit                 mirror_written [STORE_DEPTH];
  logic [COUNT_W-1:0] bytes_read;
  logic [COUNT_W-1:0] bytes_written;
  logic               read_side;
  logic               writes_open;
  logic               first_fill_done;
  logic [SB_W-1:0]    width_reg;
  logic [COUNT_W-1:0] size_reg;

  // Results still owed by the buffer, oldest first.
  buffer_result_t due_results [$];

  int unsigned requests_sent = 0;
  int unsigned source_count = 0;
  int unsigned samples_read = 0;
  int unsigned bytes_stored = 0;
  int unsigned underrun_reads = 0;
  int unsigned half_swaps = 0;
  int unsigned error_count = 0;
  bit          sender_calm = 1'b0;

  ping_pong_sample_buffer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .sample_valid (sample_valid),
    .byte_taken   (byte_taken),
    .write_ready  (write_ready),
    .finished     (finished),
    .underrun     (underrun),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the buffer
  // ---------------------------------------------------------------------------

  function automatic void restart_mirror();
    bytes_read = '0;
    bytes_written = '0;
    read_side = 1'b0;
    writes_open = 1'b1;
    first_fill_done = 1'b0;
  endfunction

  function automatic void swap_mirror();
    read_side = ~read_side;
    writes_open = 1'b1;
    half_swaps++;
  endfunction

  // Register values 0 and above 4 are clamped to the nearest legal width.
  function automatic int unsigned sample_width();
    if (width_reg == 0) return 1;
    if (width_reg > 4) return 4;
    return 32'(width_reg);
  endfunction

  function automatic bit source_done();
    return bytes_read >= size_reg;
  endfunction

  function automatic bit writer_ready();
    return writes_open && bytes_written < size_reg && !source_done();
  endfunction

  // Byte positions wrap within their half.
  function automatic int unsigned byte_slot(int unsigned half, int unsigned pos);
    return half * HALF_BYTES + pos % HALF_BYTES;
  endfunction

  // A read that delivers a sample must only touch bytes written at some point.
  function automatic bit read_safe();
    int unsigned offset;
    if (source_done() || bytes_read >= bytes_written) return 1'b1;
    offset = bytes_read % HALF_BYTES;
    for (int unsigned i = 0; i < sample_width(); i++) begin
      if (!mirror_written[byte_slot(read_side, offset + i)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one request to the mirror and return the result it must give.
  function automatic buffer_result_t advance_buffer(kind_t k, logic [BYTE_W-1:0] b);
    buffer_result_t res;
    int unsigned nb;
    int unsigned offset;
    int unsigned slot;
    longint unsigned reach;
    res = '0;
    case (k)
      KIND_RESTART: begin
        restart_mirror();
      end
      KIND_WRITE: begin
        if (writer_ready()) begin
          slot = byte_slot(read_side ^ 1'b1, bytes_written);
          mirror_bytes[slot] = b;
          mirror_written[slot] = 1'b1;
          bytes_written++;
          res.byte_taken = 1'b1;
          bytes_stored++;
          // A full half or the end of the data closes the writer; the first
          // such fill hands its half to the reader at once.
          if (bytes_written % HALF_BYTES == 0 || bytes_written == size_reg) begin
            writes_open = 1'b0;
            if (!first_fill_done) begin
              first_fill_done = 1'b1;
              swap_mirror();
            end
          end
        end
      end
      KIND_READ: begin
        if (!source_done()) begin
          if (bytes_read >= bytes_written) begin
            res.underrun = 1'b1;
            underrun_reads++;
          end else begin
            nb = sample_width();
            offset = bytes_read % HALF_BYTES;
            for (int unsigned i = 0; i < nb; i++) begin
              res.sample |= SAMPLE_W'(mirror_bytes[byte_slot(read_side, offset + i)])
                            << (BYTE_W * i);
            end
            res.sample_valid = 1'b1;
            samples_read++;
            reach = 64'(bytes_read) + nb;
            bytes_read = (reach > 64'hFFFF_FFFF) ? '1 : COUNT_W'(reach);
            if (!source_done() && bytes_read % HALF_BYTES == 0) swap_mirror();
          end
        end
      end
      default: begin
      end
    endcase
    res.write_ready = writer_ready();
    res.finished = source_done();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 9);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Send one request and record the result it must produce.
  task automatic send_request(kind_t k, logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = sender_calm ? 0 : (($urandom_range(0, 99) < 40) ? pick_gap() : 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    byte_in <= b;
    do @(posedge clk); while (in_stall);
    due_results.push_back(advance_buffer(k, b));
    if (k != KIND_NONE) requests_sent++;
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_BYTES) width_reg = data[SB_W-1:0];
    else size_reg = data;
  endtask

  task automatic set_config(int unsigned width, logic [COUNT_W-1:0] size);
    write_register(CFG_SAMPLE_BYTES, CFG_DATA_W'(width));
    write_register(CFG_DATA_SIZE, size);
  endtask

  // Drive a source forward: mostly well-formed writes and reads chosen from the
  // mirror state, with some noise when asked. Stops at the read goal, at the
  // request cap, or when nothing useful is left.
  task automatic feed_source(int unsigned cap, logic [COUNT_W-1:0] read_goal, bit noisy);
    int unsigned r;
    bit can_read;
    for (int unsigned n = 0; n < cap && bytes_read < read_goal; n++) begin
      can_read = !source_done() && bytes_read < bytes_written && read_safe();
      r = noisy ? $urandom_range(0, 99) : 99;
      if (r < 3) begin
        send_request(KIND_NONE, random_byte());
      end else if (r < 6) begin
        if (read_safe()) send_request(KIND_READ, random_byte());
      end else if (r < 9) begin
        send_request(KIND_WRITE, random_byte());
      end else if (r < 10) begin
        send_request(KIND_RESTART, random_byte());
      end else if (r < 12) begin
        pause_until_drained();
      end else if (writer_ready() && (!can_read || $urandom_range(0, 99) < 70)) begin
        send_request(KIND_WRITE, random_byte());
      end else if (can_read) begin
        send_request(KIND_READ, random_byte());
      end else begin
        // Source finished or stuck: one last read shows the final status.
        if (read_safe()) send_request(KIND_READ, random_byte());
        break;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: empty source, so writes are refused and reads are finished.
  task automatic test_empty_source();
    send_request(KIND_NONE, 8'h00);
    send_request(KIND_WRITE, 8'h33);
    send_request(KIND_READ, 8'h00);
  endtask

  // Width 0 acts as one byte; a read before any write is an underrun.
  task automatic test_single_byte_samples();
    pause_until_drained();
    set_config(0, 4);
    send_request(KIND_RESTART, 8'h00);
    send_request(KIND_READ, 8'h00);
    send_request(KIND_WRITE, 8'h00);
    send_request(KIND_WRITE, 8'hFF);
    send_request(KIND_WRITE, 8'h5A);
    send_request(KIND_WRITE, 8'hA5);
    repeat (5) send_request(KIND_READ, 8'h00);
    send_request(KIND_WRITE, 8'h77);
  endtask

  // Width 7 acts as four bytes, assembled little-endian.
  task automatic test_wide_samples();
    logic [BYTE_W-1:0] pattern [8];
    pattern = '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'hC3, 8'h3C};
    pause_until_drained();
    set_config(7, 8);
    send_request(KIND_RESTART, 8'h00);
    foreach (pattern[i]) send_request(KIND_WRITE, pattern[i]);
    repeat (2) send_request(KIND_READ, 8'h00);
  endtask

  // One long source across both half boundaries. Three-byte samples first so
  // one straddles the end of the read half, then single bytes to realign, then
  // four-byte samples up to the swap on read that reopens the writer.
  task automatic test_half_swap();
    pause_until_drained();
    set_config(3, 1040);
    send_request(KIND_RESTART, random_byte());
    feed_source(2000, 513, 1'b0);
    pause_until_drained();
    set_config(1, 1040);
    feed_source(100, 516, 1'b0);
    pause_until_drained();
    set_config(4, 1040);
    feed_source(2000, 1040, 1'b0);
  endtask

  // Random sources with random sizes, mostly short, some past a half.
  task automatic test_random_sources();
    int unsigned r;
    int unsigned cap;
    int unsigned width;
    int unsigned idx;
    logic [COUNT_W-1:0] size;
    idx = 0;
    while (requests_sent < TOTAL_ITEMS) begin
      width = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (idx == 0) begin
        size = '1;
        cap = 40;
      end else if (idx == 1 || r >= 95) begin
        size = '0;
        cap = 6;
      end else if (r < 80) begin
        size = $urandom_range(1, 40);
        cap = 3 * size + 20;
      end else if (r < 90) begin
        size = $urandom_range(513, 1100);
        cap = $urandom_range(100, 300);
      end else begin
        size = $urandom();
        cap = $urandom_range(20, 120);
      end
      if (cap > TOTAL_ITEMS - requests_sent) cap = TOTAL_ITEMS - requests_sent;
      sender_calm = ($urandom_range(0, 4) == 0);
      pause_until_drained();
      set_config(width, size);
      send_request(KIND_RESTART, random_byte());
      source_count++;
      feed_source(cap, '1, 1'b1);
      idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field_name, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, field_name, got, want);
    error_count++;
  endtask

  initial begin : result_checker
    buffer_result_t want;
    int unsigned stall_left;
    int unsigned stretch_left;
    bit calm;
    stall_left = 0;
    stretch_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no request pending", sample, '0);
        end else begin
          want = due_results.pop_front();
          if (sample !== want.sample) report_mismatch("sample", sample, want.sample);
          if (sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", sample_valid, want.sample_valid);
          if (byte_taken !== want.byte_taken)
            report_mismatch("byte_taken", byte_taken, want.byte_taken);
          if (write_ready !== want.write_ready)
            report_mismatch("write_ready", write_ready, want.write_ready);
          if (finished !== want.finished)
            report_mismatch("finished", finished, want.finished);
          if (underrun !== want.underrun)
            report_mismatch("underrun", underrun, want.underrun);
        end
      end
      // Each stretch of cycles is chosen at random to be stall-free or to carry random stalls.
      if (stretch_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(50, 300);
      end else begin
        stretch_left--;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (mirror_written[i]) mirror_written[i] = 1'b0;
    foreach (mirror_bytes[i]) mirror_bytes[i] = '0;
    width_reg = SAMPLE_BYTES_RST;
    size_reg = '0;
    restart_mirror();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_source();
    test_single_byte_samples();
    test_wide_samples();
    test_half_swap();
    test_random_sources();

    pause_until_drained();
    repeat (12) @(posedge clk);
    $display("Sent %0d requests over %0d random sources: %0d samples read, %0d bytes stored.",
             requests_sent, source_count, samples_read, bytes_stored);
    $display("Underrun reads: %0d, half swaps: %0d, mismatches: %0d.",
             underrun_reads, half_swaps, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] timeout with %0d results outstanding", $time, due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
